// ----- rtl/tpac_pkg.sv -----
`timescale 1ns / 1ps
// tpac_pkg: widths and constants shared by the triangle measure block
// no dependencies

package tpac_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int PERIM_W   = 19;
  localparam int AREA_W    = 23;

  // side arithmetic
  localparam int DIFF_W  = COORD_W + 1;
  localparam int ABS_W   = COORD_W;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int SUMSQ_W = SQ_W + 1;
  localparam int SIDE_W  = 17;

  // centroid: floor((sum + 1) / 3) via an offset and a reciprocal multiply
  localparam int CSUM_W  = COORD_W + 2;
  localparam int CT_W    = COORD_W + 4;
  localparam int CPROD_W = 2 * CT_W;
  localparam int CSHIFT  = 21;
  localparam logic [CT_W-1:0] CEN_OFS   = CT_W'(3 * (1 << (COORD_W + 2)) + 1);
  localparam logic [CT_W-1:0] CEN_RECIP = CT_W'(((1 << CSHIFT) + 1) / 3);

  // heron product
  localparam int FAC_W   = PERIM_W;
  localparam int FACS_W  = PERIM_W + 1;
  localparam int HP_W    = 2 * FAC_W;
  localparam int HALF_W  = FAC_W;
  localparam int PP_W    = 2 * HALF_W;
  localparam int MID_W   = PP_W + 1;
  localparam int PROD_W  = 2 * HP_W;
  localparam int AREA_SH = 2 * FRAC_BITS + 4;

  // pipelined square root unit
  localparam int SQ_RAD_W  = PROD_W - AREA_SH;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 3;
  localparam int SQ_TAG_W  = PERIM_W + 2 * COORD_W;

endpackage

// ----- rtl/tpac_in_if.sv -----
`timescale 1ns / 1ps
// tpac_in_if: input channel carrying one triangle word
// depends on tpac_pkg

interface tpac_in_if import tpac_pkg::*;;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] ax;
  logic signed [COORD_W-1:0] ay;
  logic signed [COORD_W-1:0] bx;
  logic signed [COORD_W-1:0] by;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;

  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

// ----- rtl/tpac_out_if.sv -----
`timescale 1ns / 1ps
// tpac_out_if: output channel carrying one result word
// depends on tpac_pkg

interface tpac_out_if import tpac_pkg::*;;
  logic valid;
  logic ready;
  logic [PERIM_W-1:0]        perimeter;
  logic [AREA_W-1:0]         area;
  logic signed [COORD_W-1:0] centroid_x;
  logic signed [COORD_W-1:0] centroid_y;

  modport source (output valid, perimeter, area, centroid_x, centroid_y, input ready);
  modport sink (input valid, perimeter, area, centroid_x, centroid_y, output ready);
endinterface

// ----- rtl/triangle_perimeter_area_centroid.sv -----
`timescale 1ns / 1ps
// triangle_perimeter_area_centroid: perimeter, heron area and centroid of a triangle
// depends on tpac_pkg, tpac_in_if, tpac_out_if and tpac_isqrt

// One triangle word (three vertices, signed Q8.8) is taken every clock cycle
// unless the output is held. Its result word passes through stages 1 to 3
// (differences, squares and sums), the side-length square-root pipelines,
// stages A1 to A5 forming the Heron product (the 38 x 38 bit multiply is split
// into four 19 x 19 partial products and summed in stages A4 and A5), the
// area square-root pipeline and one output register. Side lengths are floor
// square roots, so the perimeter is the sum of the floored sides; the area is
// zero whenever the floored sides fail the triangle inequality and
// saturates at its top code. The centroid is rounded to nearest. The whole
// pipeline holds still while a finished word waits at the output, and moves
// again as soon as that word is taken, so nothing is lost or repeated.

module triangle_perimeter_area_centroid import tpac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpac_in_if.sink     in_i,
  tpac_out_if.source  out_o
);

  logic en;
  logic out_vld_q;

  // advance whenever the output register is free or being emptied
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---- stage 1: coordinate differences and centroid sums
  logic signed [DIFF_W-1:0] dx_ab, dy_ab, dx_ac, dy_ac, dx_bc, dy_bc;
  logic                     v1_q;
  logic [ABS_W-1:0]         ux_ab_q, uy_ab_q, ux_ac_q, uy_ac_q, ux_bc_q, uy_bc_q;
  logic signed [CSUM_W-1:0] sx_q, sy_q;

  assign dx_ab = DIFF_W'(in_i.ax) - DIFF_W'(in_i.bx);
  assign dy_ab = DIFF_W'(in_i.ay) - DIFF_W'(in_i.by);
  assign dx_ac = DIFF_W'(in_i.ax) - DIFF_W'(in_i.cx);
  assign dy_ac = DIFF_W'(in_i.ay) - DIFF_W'(in_i.cy);
  assign dx_bc = DIFF_W'(in_i.bx) - DIFF_W'(in_i.cx);
  assign dy_bc = DIFF_W'(in_i.by) - DIFF_W'(in_i.cy);

  function automatic logic [ABS_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = d[DIFF_W-1] ? -d : d;
    return n[ABS_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_ab_q <= mag(dx_ab);
      uy_ab_q <= mag(dy_ab);
      ux_ac_q <= mag(dx_ac);
      uy_ac_q <= mag(dy_ac);
      ux_bc_q <= mag(dx_bc);
      uy_bc_q <= mag(dy_bc);
      sx_q    <= CSUM_W'(in_i.ax) + CSUM_W'(in_i.bx) + CSUM_W'(in_i.cx);
      sy_q    <= CSUM_W'(in_i.ay) + CSUM_W'(in_i.by) + CSUM_W'(in_i.cy);
    end
  end

  // ---- stage 2: squares, centroid reciprocal multiply
  // t = sum + 1 + 3*2^18 is always positive; t/3 is the top bits of t*recip
  logic [CT_W-1:0]    tx, ty;
  logic               v2_q;
  logic [SQ_W-1:0]    qx_ab_q, qy_ab_q, qx_ac_q, qy_ac_q, qx_bc_q, qy_bc_q;
  logic [CPROD_W-1:0] cpx_q, cpy_q;

  assign tx = CT_W'(sx_q) + CEN_OFS;
  assign ty = CT_W'(sy_q) + CEN_OFS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_ab_q <= ux_ab_q * ux_ab_q;
      qy_ab_q <= uy_ab_q * uy_ab_q;
      qx_ac_q <= ux_ac_q * ux_ac_q;
      qy_ac_q <= uy_ac_q * uy_ac_q;
      qx_bc_q <= ux_bc_q * ux_bc_q;
      qy_bc_q <= uy_bc_q * uy_bc_q;
      cpx_q   <= tx * CEN_RECIP;
      cpy_q   <= ty * CEN_RECIP;
    end
  end

  // ---- stage 3: squared lengths, centroid result
  // subtracting the offset 2^18 leaves the low 16 bits of the quotient as they are
  logic                      v3_q;
  logic [SUMSQ_W-1:0]        l_ab_q, l_ac_q, l_bc_q;
  logic signed [COORD_W-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_ab_q <= SUMSQ_W'(qx_ab_q) + SUMSQ_W'(qy_ab_q);
      l_ac_q <= SUMSQ_W'(qx_ac_q) + SUMSQ_W'(qy_ac_q);
      l_bc_q <= SUMSQ_W'(qx_bc_q) + SUMSQ_W'(qy_bc_q);
      cx_q   <= cpx_q[CSHIFT +: COORD_W];
      cy_q   <= cpy_q[CSHIFT +: COORD_W];
    end
  end

  // ---- side lengths: three square-root pipelines, centroid rides along
  logic                 vs;
  logic [SQ_ROOT_W-1:0] ra, rb, rc;
  logic [SQ_TAG_W-1:0]  tag_s;

  tpac_isqrt u_sqrt_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .rad_i  (SQ_RAD_W'(l_ab_q)),
    .tag_i  ({{PERIM_W{1'b0}}, cx_q, cy_q}),
    .vld_o  (vs),
    .root_o (ra),
    .tag_o  (tag_s)
  );

  tpac_isqrt u_sqrt_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .rad_i  (SQ_RAD_W'(l_ac_q)),
    .tag_i  ('0),
    .vld_o  (),
    .root_o (rb),
    .tag_o  ()
  );

  tpac_isqrt u_sqrt_c (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .rad_i  (SQ_RAD_W'(l_bc_q)),
    .tag_i  ('0),
    .vld_o  (),
    .root_o (rc),
    .tag_o  ()
  );

  // ---- stage A1: perimeter and heron factors s-2a, s-2b, s-2c
  logic [SIDE_W-1:0]        a, b, c;
  logic [PERIM_W-1:0]       s;
  logic signed [FACS_W-1:0] fa, fb, fc;
  logic                     pos;
  logic                     va1_q, pos_q;
  logic [PERIM_W-1:0]       s_q;
  logic [FAC_W-1:0]         fa_q, fb_q, fc_q;
  logic [2*COORD_W-1:0]     cen1_q;

  assign a   = ra[SIDE_W-1:0];
  assign b   = rb[SIDE_W-1:0];
  assign c   = rc[SIDE_W-1:0];
  assign s   = PERIM_W'(a) + PERIM_W'(b) + PERIM_W'(c);
  assign fa  = FACS_W'(s) - (FACS_W'(a) << 1);
  assign fb  = FACS_W'(s) - (FACS_W'(b) << 1);
  assign fc  = FACS_W'(s) - (FACS_W'(c) << 1);
  // degenerate or rounded-negative heron product gives zero area
  assign pos = (fa > 0) && (fb > 0) && (fc > 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va1_q <= 1'b0;
    end else if (en) begin
      va1_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q    <= s;
      pos_q  <= pos;
      fa_q   <= fa[FAC_W-1:0];
      fb_q   <= fb[FAC_W-1:0];
      fc_q   <= fc[FAC_W-1:0];
      cen1_q <= tag_s[2*COORD_W-1:0];
    end
  end

  // ---- stage A2: two half products
  logic                 va2_q;
  logic [HP_W-1:0]      x_q, y_q;
  logic [PERIM_W-1:0]   s2_q;
  logic [2*COORD_W-1:0] cen2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va2_q <= 1'b0;
    end else if (en) begin
      va2_q <= va1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q    <= pos_q ? (s_q * fa_q) : '0;
      y_q    <= fb_q * fc_q;
      s2_q   <= s_q;
      cen2_q <= cen1_q;
    end
  end

  // ---- stage A3: partial products of x*y
  logic                 va3_q;
  logic [PP_W-1:0]      hh_q, hl_q, lh_q, ll_q;
  logic [PERIM_W-1:0]   s3_q;
  logic [2*COORD_W-1:0] cen3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va3_q <= 1'b0;
    end else if (en) begin
      va3_q <= va2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh_q   <= x_q[HP_W-1 -: HALF_W] * y_q[HP_W-1 -: HALF_W];
      hl_q   <= x_q[HP_W-1 -: HALF_W] * y_q[HALF_W-1:0];
      lh_q   <= x_q[HALF_W-1:0] * y_q[HP_W-1 -: HALF_W];
      ll_q   <= x_q[HALF_W-1:0] * y_q[HALF_W-1:0];
      s3_q   <= s2_q;
      cen3_q <= cen2_q;
    end
  end

  // ---- stage A4: middle terms
  logic                 va4_q;
  logic [PP_W-1:0]      hh4_q, ll4_q;
  logic [MID_W-1:0]     mid_q;
  logic [PERIM_W-1:0]   s4_q;
  logic [2*COORD_W-1:0] cen4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va4_q <= 1'b0;
    end else if (en) begin
      va4_q <= va3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh4_q  <= hh_q;
      ll4_q  <= ll_q;
      mid_q  <= MID_W'(hl_q) + MID_W'(lh_q);
      s4_q   <= s3_q;
      cen4_q <= cen3_q;
    end
  end

  // ---- stage A5: full product, scaled down for the area root
  logic [PROD_W-1:0]    prod;
  logic                 va5_q;
  logic [SQ_RAD_W-1:0]  q_q;
  logic [SQ_TAG_W-1:0]  tag5_q;

  assign prod = {hh4_q, {PP_W{1'b0}}} + (PROD_W'(mid_q) << HALF_W) + PROD_W'(ll4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va5_q <= 1'b0;
    end else if (en) begin
      va5_q <= va4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q    <= prod[PROD_W-1:AREA_SH];
      tag5_q <= {s4_q, cen4_q};
    end
  end

  // ---- area root, perimeter and centroid ride along
  logic                 vr;
  logic [SQ_ROOT_W-1:0] rarea;
  logic [SQ_TAG_W-1:0]  tag_r;

  tpac_isqrt u_sqrt_area (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (va5_q),
    .rad_i  (q_q),
    .tag_i  (tag5_q),
    .vld_o  (vr),
    .root_o (rarea),
    .tag_o  (tag_r)
  );

  // ---- output register with area saturation
  logic [AREA_W-1:0]         area_q;
  logic [PERIM_W-1:0]        perim_q;
  logic signed [COORD_W-1:0] cenx_q, ceny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q  <= (|rarea[SQ_ROOT_W-1:AREA_W]) ? {AREA_W{1'b1}} : rarea[AREA_W-1:0];
      perim_q <= tag_r[SQ_TAG_W-1 -: PERIM_W];
      cenx_q  <= tag_r[2*COORD_W-1 -: COORD_W];
      ceny_q  <= tag_r[COORD_W-1:0];
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.perimeter  = perim_q;
  assign out_o.area       = area_q;
  assign out_o.centroid_x = cenx_q;
  assign out_o.centroid_y = ceny_q;

endmodule

// ----- rtl/tpac_isqrt.sv -----
`timescale 1ns / 1ps
// tpac_isqrt: floor integer square root, one result bit per pipeline stage
// depends on tpac_pkg

module tpac_isqrt import tpac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [SQ_RAD_W-1:0]  rad_i,
  input  logic [SQ_TAG_W-1:0]  tag_i,
  output logic                 vld_o,
  output logic [SQ_ROOT_W-1:0] root_o,
  output logic [SQ_TAG_W-1:0]  tag_o
);

  logic                 vld_q  [SQ_ROOT_W];
  logic [SQ_RAD_W-1:0]  rad_q  [SQ_ROOT_W];
  logic [SQ_REM_W-1:0]  rem_q  [SQ_ROOT_W];
  logic [SQ_ROOT_W-1:0] root_q [SQ_ROOT_W];
  logic [SQ_TAG_W-1:0]  tag_q  [SQ_ROOT_W];

  for (genvar i = 0; i < SQ_ROOT_W; i++) begin : g_stage
    logic                 vld_in;
    logic [SQ_RAD_W-1:0]  rad_in;
    logic [SQ_REM_W-1:0]  rem_in;
    logic [SQ_ROOT_W-1:0] root_in;
    logic [SQ_TAG_W-1:0]  tag_in;
    logic [SQ_REM_W-1:0]  rem_sh;
    logic [SQ_REM_W-1:0]  trial;
    logic                 ge;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign tag_in  = tag_q[i-1];
    end

    // bring down the next two radicand bits and try (4*root + 1)
    assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {rad_in[SQ_RAD_W-3:0], 2'b00};
        rem_q[i]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[i] <= {root_in[SQ_ROOT_W-2:0], ge};
        tag_q[i]  <= tag_in;
      end
    end
  end

  assign vld_o  = vld_q[SQ_ROOT_W-1];
  assign root_o = root_q[SQ_ROOT_W-1];
  assign tag_o  = tag_q[SQ_ROOT_W-1];

endmodule

// ----- verif/triangle_perimeter_area_centroid_test.sv -----
`timescale 1ns / 1ps
// triangle_perimeter_area_centroid_test: self-checking bench for the triangle measure block
// depends on tpac_pkg, tpac_in_if, tpac_out_if and the block itself

module triangle_perimeter_area_centroid_test;
  import tpac_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  } tri_word_t;

  typedef struct packed {
    logic [PERIM_W-1:0]        perimeter;
    logic [AREA_W-1:0]         area;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
  } measure_t;

  localparam int PIPE_LAT   = 65;
  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM   = 1700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tpac_in_if  tri_ch ();
  tpac_out_if meas_ch ();

  triangle_perimeter_area_centroid dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tri_ch.sink),
    .out_o  (meas_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tri_word_t tri_pending[$];
  measure_t  measure_due[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  // floor integer square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned side_of(longint x0, longint y0, longint x1, longint y1);
    longint dx, dy;
    dx = x0 - x1;
    dy = y0 - y1;
    return root_floor(longint'(dx * dx + dy * dy));
  endfunction

  // round-to-nearest mean of three, sum never lands on a half
  function automatic logic signed [COORD_W-1:0] mean_of3(longint sum);
    longint ofs;
    ofs = longint'(1) << (COORD_W + 2);
    return COORD_W'((sum + 1 + 3 * ofs) / 3 - ofs);
  endfunction

  function automatic measure_t measure_triangle(tri_word_t t);
    measure_t m;
    longint unsigned sa, sb, sc, s;
    longint fa, fb, fc;
    logic [127:0] prod;
    logic [127:0] q;
    longint unsigned ar;
    sa = side_of(t.ax, t.ay, t.bx, t.by);
    sb = side_of(t.ax, t.ay, t.cx, t.cy);
    sc = side_of(t.bx, t.by, t.cx, t.cy);
    s  = sa + sb + sc;
    m.perimeter = (s > (2**PERIM_W - 1)) ? {PERIM_W{1'b1}} : PERIM_W'(s);
    fa = longint'(s) - 2 * longint'(sa);
    fb = longint'(s) - 2 * longint'(sb);
    fc = longint'(s) - 2 * longint'(sc);
    m.area = '0;
    // floored sides breaking the triangle inequality give zero area
    if (fa > 0 && fb > 0 && fc > 0) begin
      prod = 128'(s) * 128'(fa) * 128'(fb) * 128'(fc);
      q = prod >> (2 * FRAC_BITS + 4);
      if (q[127:64] != 0) ar = 64'hffff_ffff_ffff_ffff;
      else ar = root_floor(q[63:0]);
      m.area = (ar > (2**AREA_W - 1)) ? {AREA_W{1'b1}} : AREA_W'(ar);
    end
    m.centroid_x = mean_of3(longint'(t.ax) + t.bx + t.cx);
    m.centroid_y = mean_of3(longint'(t.ay) + t.by + t.cy);
    return m;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff - COORD_W'($urandom_range(0, 3));
      1: return 16'sh8000 + COORD_W'($urandom_range(0, 3));
      2: return COORD_W'($urandom_range(0, 2047)) - 16'sd1024;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // driver: one word per accepted handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_ch.valid <= 1'b0;
      {tri_ch.ax, tri_ch.ay, tri_ch.bx, tri_ch.by, tri_ch.cx, tri_ch.cy} <= '0;
    end else begin
      if (tri_ch.valid && tri_ch.ready) begin
        measure_due.push_back(measure_triangle({tri_ch.ax, tri_ch.ay, tri_ch.bx,
                                                tri_ch.by, tri_ch.cx, tri_ch.cy}));
      end
      if (!tri_ch.valid || tri_ch.ready) begin
        if (tri_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tri_word_t t;
          t = tri_pending.pop_front();
          tri_ch.valid <= 1'b1;
          {tri_ch.ax, tri_ch.ay, tri_ch.bx, tri_ch.by, tri_ch.cx, tri_ch.cy} <= t;
        end else begin
          tri_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      meas_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if ((tri_ch.valid && tri_ch.ready) || (meas_ch.valid && meas_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (meas_ch.valid && meas_ch.ready) begin
        measure_t got, want;
        got = {meas_ch.perimeter, meas_ch.area, meas_ch.centroid_x, meas_ch.centroid_y};
        if (measure_due.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word %p", got);
        end else begin
          want = measure_due.pop_front();
          if (got != want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: perim %0d/%0d area %0d/%0d cx %0d/%0d cy %0d/%0d (exp/got)",
                       want.perimeter, got.perimeter, want.area, got.area,
                       want.centroid_x, got.centroid_x, want.centroid_y, got.centroid_y);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_tri(int ax, int ay, int bx, int by, int cx, int cy);
    tri_pending.push_back({COORD_W'(ax), COORD_W'(ay), COORD_W'(bx),
                           COORD_W'(by), COORD_W'(cx), COORD_W'(cy)});
  endtask

  task automatic drain_queue();
    while (tri_pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    tri_word_t t;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, coincident and collinear points, right and thin triangles
    add_tri(0, 0, 0, 0, 0, 0);
    add_tri(32767, 32767, 32767, 32767, 32767, 32767);
    add_tri(-32768, -32768, -32768, -32768, -32768, -32768);
    add_tri(-32768, -32768, 32767, -32768, -32768, 32767);
    add_tri(32767, 32767, -32768, 32767, 32767, -32768);
    add_tri(-32768, 32767, 32767, -32768, -32768, -32768);
    add_tri(0, 0, 256, 256, 512, 512);
    add_tri(0, 0, 768, 0, 0, 1024);
    add_tri(0, 0, 1, 0, 0, 1);
    add_tri(0, 0, 3, 0, 1, 1);
    add_tri(-1, -1, 0, 0, 0, 0);
    add_tri(1, 2, 0, 0, 0, 0);
    add_tri(-1, -2, 0, 0, 0, 0);
    add_tri(0, 0, 10000, 1, -10000, 0);
    add_tri(-32768, 0, 32767, 0, 0, 32767);
    add_tri(-21846, 21845, -21845, 21846, 32767, -32768);
    add_tri(100, -200, -300, 400, 500, -600);
    add_tri(21845, -21846, 21846, -21845, 21846, 0);
    drain_queue();

    // random phases with changing idle and stall pressure
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        3: begin send_idle_pct = 26; recv_stall_pct = 26; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        t.ax = rand_coord(); t.ay = rand_coord();
        // sometimes cluster B and C near A for small, thin or degenerate shapes
        if ($urandom_range(0, 3) == 0) begin
          t.bx = t.ax + COORD_W'($urandom_range(0, 15)) - 16'sd8;
          t.by = t.ay + COORD_W'($urandom_range(0, 15)) - 16'sd8;
          t.cx = t.ax + COORD_W'($urandom_range(0, 15)) - 16'sd8;
          t.cy = t.ay + COORD_W'($urandom_range(0, 15)) - 16'sd8;
        end else begin
          t.bx = rand_coord(); t.by = rand_coord();
          t.cx = rand_coord(); t.cy = rand_coord();
        end
        tri_pending.push_back(t);
      end
      drain_queue();
    end

    while (measure_due.size() != 0 || tri_ch.valid) @(posedge clk_i);
    repeat (2 * PIPE_LAT) @(posedge clk_i);
    if (mismatches == 0 && measure_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
